// ----- src/rbf_pkg.sv -----
// Package for the RGB565 rotated blit with fade unit.
// Holds register indexes, reset values, field widths and the per-byte fade
// function. No dependencies.
package rbf_pkg;

  localparam int IDX_W  = 18;  // framebuffer pixel index width
  localparam int DIM_W  = 11;  // clamped width/height, up to 1024
  localparam int ADDR_W = 5;   // byte address of the register file

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd2;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd3;
  localparam logic [2:0] REG_FADE_ENABLE  = 3'd4;
  localparam logic [2:0] REG_FADE_WEIGHT  = 3'd5;

  localparam logic [8:0] ORIGIN_X_RST     = 9'd0;
  localparam logic [7:0] ORIGIN_Y_RST     = 8'd0;
  localparam logic [9:0] FRAME_WIDTH_RST  = 10'd400;
  localparam logic [8:0] FRAME_HEIGHT_RST = 9'd240;
  localparam logic       FADE_ENABLE_RST  = 1'b0;
  localparam logic [8:0] FADE_WEIGHT_RST  = 9'd128;

  localparam logic [8:0] WEIGHT_FULL = 9'd256;

  typedef logic [7:0] byte_t;

  // Blend one byte toward white. w is already clamped to 0..256.
  // floor((a*256 + 255*w)/256) reduces to a + floor(255*w/256) = a + w - (w != 0).
  function automatic byte_t fade_byte(input byte_t c, input logic [8:0] w);
    logic [8:0]  inv;
    logic [16:0] prod;
    logic [7:0]  a;
    logic [7:0]  w_add;
    inv   = WEIGHT_FULL - w;
    prod  = {9'd0, c} * {8'd0, inv};
    a     = prod[15:8];
    w_add = (w == 9'd0) ? 8'd0 : 8'(w - 9'd1);
    return 8'(a + w_add);
  endfunction

endpackage

// ----- src/rgb565_rotated_blit_with_fade_unit.sv -----
// RGB565 rotated blit with fade toward white: top level.
// Depends on rbf_pkg for register indexes, reset values and the fade function.
//
// Usage:
//   Input channel (in_valid/in_ready/in_pixel_565) takes camera pixels in raster
//   order. Column and row counters track the position; a row ends when the
//   column reaches the clamped frame width minus 1, the frame ends when the row
//   reaches the clamped frame height minus 1 on a row end.
//   Result channel (out_valid/out_ready) returns the rotated framebuffer
//   index, three expanded (and optionally faded) bytes and the last-pixel flag.
//   An accepted item passes through the input register, then the result
//   register; out_valid rises when the result register is loaded.
//   Throughput: one item per cycle unless the receiver stalls; the index
//   multiply and the three fade multiplies all sit in the single stage between input and result register.
//   Receiver stall: the result register holds; the input stage still takes
//   one more item, then in_ready drops until out_ready returns.
//   Reset (rst_n low, synchronous): pipeline emptied, counters cleared,
//   registers to defaults (origin 0,0; 400x240; fade off; weight 128).
//   Configuration: APB-style, register i at byte address 4*i; registers must be
//   written by the user only while no item is in flight, which the block does not enforce.
module rgb565_rotated_blit_with_fade_unit
  import rbf_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       in_pixel_565,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_pixel_index,
  output logic [7:0]        out_byte0,
  output logic [7:0]        out_byte1,
  output logic [7:0]        out_byte2,
  output logic              out_last_pixel
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XW = 12;  // origin_x + column

  // ---------------- configuration registers ----------------
  logic [8:0] origin_x_r;
  logic [7:0] origin_y_r;
  logic [9:0] frame_width_r;
  logic [8:0] frame_height_r;
  logic       fade_enable_r;
  logic [8:0] fade_weight_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= ORIGIN_X_RST;
      origin_y_r     <= ORIGIN_Y_RST;
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      fade_enable_r  <= FADE_ENABLE_RST;
      fade_weight_r  <= FADE_WEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ORIGIN_X:     origin_x_r     <= pwdata[8:0];
        REG_ORIGIN_Y:     origin_y_r     <= pwdata[7:0];
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[9:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[8:0];
        REG_FADE_ENABLE:  fade_enable_r  <= pwdata[0];
        REG_FADE_WEIGHT:  fade_weight_r  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ORIGIN_X:     prdata = {23'd0, origin_x_r};
      REG_ORIGIN_Y:     prdata = {24'd0, origin_y_r};
      REG_FRAME_WIDTH:  prdata = {22'd0, frame_width_r};
      REG_FRAME_HEIGHT: prdata = {23'd0, frame_height_r};
      REG_FADE_ENABLE:  prdata = {31'd0, fade_enable_r};
      REG_FADE_WEIGHT:  prdata = {23'd0, fade_weight_r};
      default:          prdata = 32'd0;
    endcase
  end

  // clamped geometry: zero means one, above the maximum saturates
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [DIM_W-1:0] fw_ext;
  logic [DIM_W-1:0] fh_ext;
  logic [8:0]       weight_eff;

  assign fw_ext = DIM_W'(frame_width_r);
  assign fh_ext = DIM_W'(frame_height_r);

  always_comb begin
    priority if (fw_ext == '0)                  w_eff = DIM_W'(1);
    else if (fw_ext > DIM_W'(MAX_WIDTH))        w_eff = DIM_W'(MAX_WIDTH);
    else                                        w_eff = fw_ext;
    priority if (fh_ext == '0)                  h_eff = DIM_W'(1);
    else if (fh_ext > DIM_W'(MAX_HEIGHT))       h_eff = DIM_W'(MAX_HEIGHT);
    else                                        h_eff = fh_ext;
  end

  assign weight_eff = (fade_weight_r > WEIGHT_FULL) ? WEIGHT_FULL : fade_weight_r;

  // ---------------- pipeline control ----------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic adv, in_acc, s1_move;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;
  assign in_acc   = in_valid && in_ready;
  assign s1_move  = s1_valid_r && adv;

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
    out_valid_nxt = adv ? s1_valid_r : out_valid_r;
  end

  // ---------------- position counters ----------------
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          row_end, frame_end;

  assign row_end   = DIM_W'(col_r) >= (w_eff - DIM_W'(1));
  assign frame_end = row_end && (DIM_W'(row_r) >= (h_eff - DIM_W'(1)));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
    end
  end

  // ---------------- input stage ----------------
  logic [15:0]   s1_pixel_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  logic          s1_last_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel_r <= in_pixel_565;
      s1_col_r   <= col_r;
      s1_row_r   <= row_r;
      s1_last_r  <= frame_end;
    end
  end

  // ---------------- compute stage ----------------
  logic [XW-1:0]        x_sum;
  logic [XW+DIM_W-1:0]  x_prod;
  logic [IDX_W-1:0]     idx_calc;
  byte_t                c0, c1, c2;
  byte_t                b0, b1, b2;

  assign x_sum  = XW'(origin_x_r) + XW'(s1_col_r);
  assign x_prod = (XW+DIM_W)'(x_sum) * (XW+DIM_W)'(h_eff);
  // rotated index, wrapping modulo 2^IDX_W
  assign idx_calc = IDX_W'(origin_y_r) + IDX_W'(h_eff) - IDX_W'(1) - IDX_W'(s1_row_r)
                  + x_prod[IDX_W-1:0];

  assign c0 = {s1_pixel_r[4:0], 3'b000};
  assign c1 = {s1_pixel_r[10:5], 2'b00};
  assign c2 = {s1_pixel_r[15:11], 3'b000};

  assign b0 = fade_enable_r ? fade_byte(c0, weight_eff) : c0;
  assign b1 = fade_enable_r ? fade_byte(c1, weight_eff) : c1;
  assign b2 = fade_enable_r ? fade_byte(c2, weight_eff) : c2;

  // ---------------- result register ----------------
  logic [IDX_W-1:0] out_idx_r;
  byte_t            out_b0_r, out_b1_r, out_b2_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_idx_r  <= idx_calc;
      out_b0_r   <= b0;
      out_b1_r   <= b1;
      out_b2_r   <= b2;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_idx_r;
  assign out_byte0       = out_b0_r;
  assign out_byte1       = out_b1_r;
  assign out_byte2       = out_b2_r;
  assign out_last_pixel  = out_last_r;

  // ---------------- assertions ----------------
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    DIM_W'(col_r) < DIM_W'(MAX_WIDTH))
    else $error("column counter beyond maximum width");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && row_end) |=> (col_r == '0))
    else $error("column counter did not clear at row end");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !row_end) |=> (col_r == $past(col_r) + CW'(1) && row_r == $past(row_r)))
    else $error("column counter did not advance");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input held off while pipeline has room");

endmodule

// ----- tb/blit_tb_pkg.sv -----
`timescale 1ns / 100ps
// Pixel tracker for the RGB565 rotated blit unit. It predicts the framebuffer
// write for each accepted pixel and checks the returned writes in order.
// Depends on rbf_pkg for register indexes, reset values and field widths.
package blit_tb_pkg;
  import rbf_pkg::*;

  localparam int unsigned WIDTH_CAP  = 512;
  localparam int unsigned HEIGHT_CAP = 256;
  localparam int unsigned WEIGHT_CAP = 256;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    byte_t            b0;
    byte_t            b1;
    byte_t            b2;
    logic             last;
  } fb_write_t;

  class blit_tracker;
    logic [8:0]  org_x;
    logic [7:0]  org_y;
    logic [9:0]  width_reg;
    logic [8:0]  height_reg;
    logic        fade_on;
    logic [8:0]  weight_reg;
    int unsigned col;
    int unsigned row;
    int          errors;
    fb_write_t   expected_writes[$];

    function new();
      org_x      = ORIGIN_X_RST;
      org_y      = ORIGIN_Y_RST;
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      fade_on    = FADE_ENABLE_RST;
      weight_reg = FADE_WEIGHT_RST;
      col        = 0;
      row        = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_ORIGIN_X:     org_x = val[8:0];
        REG_ORIGIN_Y:     org_y = val[7:0];
        REG_FRAME_WIDTH:  width_reg = val[9:0];
        REG_FRAME_HEIGHT: height_reg = val[8:0];
        REG_FADE_ENABLE:  fade_on = val[0];
        REG_FADE_WEIGHT:  weight_reg = val[8:0];
        default: ;
      endcase
    endfunction

    static function int unsigned clamp_dim(int unsigned v, int unsigned cap);
      if (v == 0) return 1;
      return (v > cap) ? cap : v;
    endfunction

    static function byte_t blend_white(int unsigned c, int unsigned w);
      int unsigned dimmed;
      dimmed = (c * (256 - w)) >> 8;
      return byte_t'(((dimmed << 8) + 255 * w) >> 8);
    endfunction

    function void note_pixel(logic [15:0] pix);
      int unsigned w;
      int unsigned h;
      int unsigned idx;
      int unsigned wt;
      int unsigned c0;
      int unsigned c1;
      int unsigned c2;
      logic        row_end;
      logic        frame_end;
      fb_write_t   wr;
      w  = clamp_dim(width_reg, WIDTH_CAP);
      h  = clamp_dim(height_reg, HEIGHT_CAP);
      c0 = {pix[4:0], 3'b000};
      c1 = {pix[10:5], 2'b00};
      c2 = {pix[15:11], 3'b000};
      // counters left past the end by a geometry change still end the row/frame
      row_end   = (col >= w - 1);
      frame_end = row_end && (row >= h - 1);
      // 32-bit wrap, then keep the low index bits
      idx = (org_y + h - 1 - row) + (org_x + col) * h;
      if (fade_on) begin
        wt = (weight_reg > WEIGHT_CAP) ? WEIGHT_CAP : weight_reg;
        c0 = blend_white(c0, wt);
        c1 = blend_white(c1, wt);
        c2 = blend_white(c2, wt);
      end
      wr.index = IDX_W'(idx);
      wr.b0    = byte_t'(c0);
      wr.b1    = byte_t'(c1);
      wr.b2    = byte_t'(c2);
      wr.last  = frame_end;
      expected_writes.push_back(wr);
      if (row_end) begin
        col = 0;
        row = frame_end ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void flag(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      end
    endfunction

    function void check_write(fb_write_t got);
      fb_write_t want;
      if (expected_writes.size() == 0) begin
        errors++;
        $error("write with no pixel outstanding: pixel_index %0d", got.index);
        return;
      end
      want = expected_writes.pop_front();
      flag("pixel_index", want.index, got.index);
      flag("byte0", want.b0, got.b0);
      flag("byte1", want.b1, got.b1);
      flag("byte2", want.b2, got.b2);
      flag("last_pixel", want.last, got.last);
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for rgb565_rotated_blit_with_fade_unit: drives pixels and
// register writes, stalls the result side and checks every framebuffer write.
// Depends on rbf_pkg and blit_tb_pkg.
module tb_top;
  import rbf_pkg::*;
  import blit_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TARGET_ITEMS = 1100;
  localparam int MAX_GAP      = 13;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [ADDR_W-1:0] paddr        = '0;
  logic [31:0]       pwdata       = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [15:0]       in_pixel_565 = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [IDX_W-1:0]  out_pixel_index;
  logic [7:0]        out_byte0;
  logic [7:0]        out_byte1;
  logic [7:0]        out_byte2;
  logic              out_last_pixel;

  blit_tracker sb;
  bit          hold_req     = 1'b0;
  int          rx_max_stall = MAX_GAP;
  int          cycles       = 0;
  int          sent         = 0;

  logic [15:0] corner_pixels [5] = '{16'h0000, 16'hFFFF, 16'h001F, 16'h07E0, 16'hF800};

  always #4 clk = ~clk;

  rgb565_rotated_blit_with_fade_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel_565    (in_pixel_565),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_index (out_pixel_index),
    .out_byte0       (out_byte0),
    .out_byte1       (out_byte1),
    .out_byte2       (out_byte2),
    .out_last_pixel  (out_last_pixel)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Tasks start and end just after a falling edge.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_all(input logic [31:0] ox, input logic [31:0] oy,
                         input logic [31:0] w, input logic [31:0] h,
                         input logic [31:0] fe, input logic [31:0] fw);
    reg_write(REG_ORIGIN_X, ox);
    reg_write(REG_ORIGIN_Y, oy);
    reg_write(REG_FRAME_WIDTH, w);
    reg_write(REG_FRAME_HEIGHT, h);
    reg_write(REG_FADE_ENABLE, fe);
    reg_write(REG_FADE_WEIGHT, fw);
  endtask

  // Hold until every predicted write is back, then let the pipe settle.
  task automatic drain();
    while (sb.expected_writes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_pixel(input logic [15:0] pix, input int gap_after);
    in_valid     <= 1'b1;
    in_pixel_565 <= pix;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(pix);
    sent++;
    @(negedge clk);
    if (gap_after > 0) begin
      in_valid <= 1'b0;
      repeat (gap_after) @(negedge clk);
    end
  endtask

  task automatic send_run(input int n, input int gap_max);
    logic [15:0] pix;
    int          gap;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0)
        pix = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
      else
        pix = 16'($urandom);
      gap = $urandom_range(0, gap_max);
      // drop valid after the last item of a run
      if (i == n - 1) gap = gap + 1;
      send_pixel(pix, gap);
    end
  endtask

  function automatic logic [31:0] pick_span(int unsigned hi);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  function automatic logic [31:0] pick_dim(int unsigned small_hi, int unsigned cap,
                                           int unsigned field_max);
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, small_hi);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return cap;
      2: return field_max;
      default: return $urandom_range(0, field_max);
    endcase
  endfunction

  // Result side: random stalls, an occasional long hold-off on request.
  initial begin
    int        stall;
    fb_write_t got;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0)
        rx_max_stall = ($urandom_range(0, 1) == 0) ? 0 : MAX_GAP;
      stall = $urandom_range(0, rx_max_stall);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(48, 80)) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.index = out_pixel_index;
      got.b0    = out_byte0;
      got.b1    = out_byte1;
      got.b2    = out_byte2;
      got.last  = out_last_pixel;
      sb.check_write(got);
      @(negedge clk);
    end
  end

  initial begin
    int base;
    int phase;
    bit all_regs;
    sb = new();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset geometry, no fade: channel extremes
    foreach (corner_pixels[i]) send_pixel(corner_pixels[i], (i == 4) ? 1 : 0);
    drain();
    // zero size acts as 1x1, so every pixel ends the frame; zero weight
    set_all(511, 255, 0, 0, 1, 0);
    send_pixel(16'hFFFF, 0);
    send_pixel(16'h0000, 2);
    send_pixel(16'h5AA5, 1);
    drain();
    // largest frame, far origin, full white
    set_all(511, 255, 512, 256, 1, 256);
    send_pixel(16'hFFFF, 0);
    send_pixel(16'h8410, 0);
    send_pixel(16'h0000, 1);
    drain();
    // oversized width, height and weight saturate
    set_all(0, 0, 1023, 511, 1, 511);
    send_pixel(16'hFFFF, 3);
    send_pixel(16'h7BEF, 0);
    send_pixel(16'h1234, 1);
    drain();
    // shrink the frame mid-way: column and row end up past the new ends
    set_all(3, 0, 3, 4, 1, 77);
    send_run(7, 0);
    drain();
    set_all(3, 0, 1, 2, 0, 77);
    send_run(2, 2);
    drain();

    base  = sent;
    phase = 0;
    while (sent - base < TARGET_ITEMS) begin
      drain();
      all_regs = (phase == 0);
      if (all_regs || $urandom_range(0, 1)) reg_write(REG_ORIGIN_X, pick_span(511));
      if (all_regs || $urandom_range(0, 1)) reg_write(REG_ORIGIN_Y, pick_span(255));
      if (all_regs || $urandom_range(0, 1))
        reg_write(REG_FRAME_WIDTH, pick_dim(9, 512, 1023));
      if (all_regs || $urandom_range(0, 1))
        reg_write(REG_FRAME_HEIGHT, pick_dim(7, 256, 511));
      if (all_regs || $urandom_range(0, 1)) reg_write(REG_FADE_ENABLE, $urandom_range(0, 1));
      if (all_regs || $urandom_range(0, 1)) reg_write(REG_FADE_WEIGHT, pick_span(511));
      if (phase % 8 == 0) begin
        // receiver holds off while items keep coming, so the input stalls
        hold_req = 1'b1;
        send_run(40, 0);
      end else begin
        send_run($urandom_range(4, 60), ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP);
      end
      phase++;
    end
    drain();

    if (sb.errors == 0 && sb.expected_writes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- rgb565_rotated_blit_with_fade_unit.f -----
src/rbf_pkg.sv
src/rgb565_rotated_blit_with_fade_unit.sv
tb/blit_tb_pkg.sv
tb/tb_top.sv
